[hw/rtl/dhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types and constants for the DH chain axis/offset converter.
// ----------------------------------------------------------------------------
package dhc_pkg;

  // Internal CORDIC format: 30 fraction bits, angle 2^31 = pi
  localparam int CordFrac  = 30;
  localparam int CordW     = 34;
  localparam logic [31:0] CordGain = 32'd652032874;

  typedef enum logic [1:0] {
    KIND_AXIS   = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_ROW    = 2'd2
  } kind_e;

  // Multiplier operand selects
  typedef enum logic [1:0] {
    MA_COL0 = 2'd0,
    MA_COL1 = 2'd1,
    MA_COL2 = 2'd2
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_LEN = 2'd0,
    MB_OFS = 2'd1,
    MB_COS = 2'd2,
    MB_SIN = 2'd3
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    acc_op_e acc_op;
    logic    cap_n1;
    logic    push_off;
    logic    write_row;
    logic    rotate;
    logic    out_load;
    kind_e   out_kind;
    logic [1:0] out_row;
    logic    out_last;
  } dhc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic cord_done;
    logic chain_end;
  } dhc_stat_t;

  // Arctangent table, angle units of 2^31 = pi
  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/dhc_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin
// of a binary angle rounded to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module dhc_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [15:0]            angle_i,
  output logic signed [FRAC_BITS+1:0]   cos_o,
  output logic signed [FRAC_BITS+1:0]   sin_o,
  output logic                          done_o
);
  import dhc_pkg::*;

  localparam int EW   = FRAC_BITS + 2;
  localparam int CntW = $clog2(CORDIC_STEPS + 1);
  localparam int Rs   = CordFrac - FRAC_BITS;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    run_q, run_d, done_q, done_d, neg_q, neg_d;
  logic signed [EW-1:0]    cos_q, cos_d, sin_q, sin_d;

  logic signed [16:0]       ang_w, ang_f;
  logic signed [CordW-1:0]  dx, dy, at, xr, yr, xc, yc, one_fx;

  // Fold the angle into +-pi/2
  always_comb begin
    ang_w = 17'(angle_i);
    ang_f = ang_w;
    if (ang_w > 17'sd16384) begin
      ang_f = ang_w - 17'sd32768;
    end else if (ang_w < -17'sd16384) begin
      ang_f = ang_w + 17'sd32768;
    end
  end

  // Micro-rotation and final rounding
  always_comb begin
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    at     = CordW'(atan_at(5'(cnt_q)));
    one_fx = CordW'(1) <<< FRAC_BITS;
    xr     = (x_q + (CordW'(1) <<< (Rs - 1))) >>> Rs;
    yr     = (y_q + (CordW'(1) <<< (Rs - 1))) >>> Rs;
    xc     = (xr > one_fx) ? one_fx : ((xr < -one_fx) ? -one_fx : xr);
    yc     = (yr > one_fx) ? one_fx : ((yr < -one_fx) ? -one_fx : yr);
    if (neg_q) begin
      xc = -xc;
      yc = -yc;
    end

    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    cos_d  = cos_q;
    sin_d  = sin_q;

    if (start_i) begin
      x_d    = CordW'(CordGain);
      y_d    = '0;
      z_d    = CordW'(ang_f) <<< 16;
      neg_d  = (ang_w > 17'sd16384) || (ang_w < -17'sd16384);
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      if (cnt_q == CntW'(CORDIC_STEPS)) begin
        cos_d  = EW'(xc);
        sin_d  = EW'(yc);
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        if (z_q >= 0) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign done_o = done_q;

endmodule

[hw/rtl/dhc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_datapath
// Rotation rows, shared multiplier and accumulator, offset store and the
// output word register.
// ----------------------------------------------------------------------------
module dhc_datapath #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhc_pkg::dhc_cmd_t   cmd_i,
  output dhc_pkg::dhc_stat_t  stat_o,
  input  logic signed [15:0]  twist_angle_i,
  input  logic signed [31:0]  link_length_i,
  input  logic signed [31:0]  link_offset_i,
  input  logic                chain_start_i,
  input  logic                chain_end_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [1:0]          result_kind_o,
  output logic [1:0]          row_index_o,
  output logic signed [31:0]  comp_x_o,
  output logic signed [31:0]  comp_y_o,
  output logic signed [31:0]  comp_z_o,
  output logic                run_last_o
);
  import dhc_pkg::*;

  localparam int EW = FRAC_BITS + 2;
  localparam int PW = EW + 32;
  localparam int AW = PW + 1;
  localparam logic signed [AW-1:0] OutMax = (AW'(1) <<< 31) - AW'(1);
  localparam logic signed [AW-1:0] OutMin = -(AW'(1) <<< 31);
  localparam logic signed [AW-1:0] EntMax = (AW'(1) <<< (FRAC_BITS + 1)) - AW'(1);
  localparam logic signed [AW-1:0] EntMin = -(AW'(1) <<< (FRAC_BITS + 1));
  localparam logic signed [EW-1:0] OneFx  = EW'(1) <<< FRAC_BITS;

  logic signed [EW-1:0] rows_q [3][3];
  logic signed [31:0]   len_q, ofs_q;
  logic                 end_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_d, rnd;
  logic signed [EW-1:0] n1_q, ent_sat;
  logic signed [31:0]   off_q [3];
  logic signed [31:0]   out_sat;
  logic signed [EW-1:0] ma;
  logic signed [31:0]   mb;
  logic signed [EW-1:0] cos_w, sin_w;
  logic                 cord_done;

  logic                 out_valid_q;
  logic [1:0]           kind_q, row_q;
  logic signed [31:0]   cx_q, cy_q, cz_q;
  logic                 last_q;

  dhc_cordic #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.load_item),
    .angle_i(twist_angle_i),
    .cos_o  (cos_w),
    .sin_o  (sin_w),
    .done_o (cord_done)
  );

  // Select multiplier operands: a head-row entry and a joint or CORDIC value
  always_comb begin
    case (cmd_i.mul_a)
      MA_COL0: ma = rows_q[0][0];
      MA_COL1: ma = rows_q[0][1];
      MA_COL2: ma = rows_q[0][2];
      default: ma = '0;
    endcase
    case (cmd_i.mul_b)
      MB_LEN:  mb = len_q;
      MB_OFS:  mb = ofs_q;
      MB_COS:  mb = 32'(cos_w);
      MB_SIN:  mb = 32'(sin_w);
      default: mb = '0;
    endcase
  end

  // Accumulate, round half up and saturate
  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = AW'(prod_q);
      ACC_ADD:  acc_d = acc_q + AW'(prod_q);
      ACC_SUB:  acc_d = acc_q - AW'(prod_q);
      default:  acc_d = acc_q;
    endcase
    rnd     = (acc_q + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    out_sat = (rnd > OutMax) ? 32'(OutMax) : ((rnd < OutMin) ? 32'(OutMin) : 32'(rnd));
    ent_sat = (rnd > EntMax) ? EW'(EntMax) : ((rnd < EntMin) ? EW'(EntMin) : EW'(rnd));
  end

  // Multiply, accumulate and capture
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(ma) * PW'(mb);
    acc_q  <= acc_d;
    if (cmd_i.cap_n1) begin
      n1_q <= ent_sat;
    end
    if (cmd_i.push_off) begin
      off_q[2] <= out_sat;
      off_q[1] <= off_q[2];
      off_q[0] <= off_q[1];
    end
    if (cmd_i.load_item) begin
      len_q <= link_length_i;
      ofs_q <= link_offset_i;
    end
  end

  // Hold the running rotation; rows circulate through the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rows_q[r][c] <= (r == c) ? OneFx : '0;
        end
      end
      end_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      end_q <= chain_end_i;
      if (chain_start_i) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            rows_q[r][c] <= (r == c) ? OneFx : '0;
          end
        end
      end
    end else if (cmd_i.rotate) begin
      rows_q[0] <= rows_q[1];
      rows_q[1] <= rows_q[2];
      if (cmd_i.write_row) begin
        rows_q[2][0] <= rows_q[0][0];
        rows_q[2][1] <= n1_q;
        rows_q[2][2] <= ent_sat;
      end else begin
        rows_q[2] <= rows_q[0];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      row_q  <= cmd_i.out_row;
      last_q <= cmd_i.out_last;
      case (cmd_i.out_kind)
        KIND_AXIS: begin
          cx_q <= 32'(rows_q[0][2]);
          cy_q <= 32'(rows_q[1][2]);
          cz_q <= 32'(rows_q[2][2]);
        end
        KIND_OFFSET: begin
          cx_q <= off_q[0];
          cy_q <= off_q[1];
          cz_q <= off_q[2];
        end
        default: begin
          cx_q <= 32'(rows_q[0][0]);
          cy_q <= 32'(rows_q[0][1]);
          cz_q <= 32'(rows_q[0][2]);
        end
      endcase
    end
  end

  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.cord_done = cord_done;
  assign stat_o.chain_end = end_q;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign row_index_o   = row_q;
  assign comp_x_o      = cx_q;
  assign comp_y_o      = cy_q;
  assign comp_z_o      = cz_q;
  assign run_last_o    = last_q;

endmodule

[hw/rtl/dhc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhc_ctrl
// Sequencer: issues the per-row multiply steps and the output words.
// ----------------------------------------------------------------------------
module dhc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dhc_pkg::dhc_stat_t stat_i,
  output dhc_pkg::dhc_cmd_t  cmd_o
);
  import dhc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_AXIS  = 7'b0000010,
    ST_OFF   = 7'b0000100,
    ST_OFFE  = 7'b0001000,
    ST_CWAIT = 7'b0010000,
    ST_ROT   = 7'b0100000,
    ST_ROWS  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [2:0] ph_q, ph_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    ph_d    = ph_q;
    cmd_o   = '0;
    cmd_o.mul_a    = MA_COL0;
    cmd_o.mul_b    = MB_LEN;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.out_kind = KIND_AXIS;

    case (state_q)
      // Take a joint word and start the CORDIC
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_AXIS;
          row_d   = '0;
          ph_d    = '0;
          state_d = ST_OFF;
        end
      end
      // Offset row: h0*a + h2*d
      ST_OFF: begin
        ph_d = ph_q + 3'd1;
        case (ph_q)
          3'd0: begin
            cmd_o.mul_a = MA_COL0;
            cmd_o.mul_b = MB_LEN;
          end
          3'd1: begin
            cmd_o.mul_a  = MA_COL2;
            cmd_o.mul_b  = MB_OFS;
            cmd_o.acc_op = ACC_LOAD;
          end
          3'd2: cmd_o.acc_op = ACC_ADD;
          default: begin
            cmd_o.push_off = 1'b1;
            cmd_o.rotate   = 1'b1;
            ph_d  = '0;
            row_d = row_q + 2'd1;
            if (row_q == 2'd2) begin
              state_d = ST_OFFE;
            end
          end
        endcase
      end
      ST_OFFE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_OFFSET;
          cmd_o.out_last = !stat_i.chain_end;
          state_d = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (stat_i.cord_done) begin
          row_d   = '0;
          ph_d    = '0;
          state_d = ST_ROT;
        end
      end
      // Rotation row: new1 = m1*c + m2*s, new2 = m2*c - m1*s
      ST_ROT: begin
        ph_d = ph_q + 3'd1;
        case (ph_q)
          3'd0: begin
            cmd_o.mul_a = MA_COL1;
            cmd_o.mul_b = MB_COS;
          end
          3'd1: begin
            cmd_o.mul_a  = MA_COL2;
            cmd_o.mul_b  = MB_SIN;
            cmd_o.acc_op = ACC_LOAD;
          end
          3'd2: begin
            cmd_o.mul_a  = MA_COL2;
            cmd_o.mul_b  = MB_COS;
            cmd_o.acc_op = ACC_ADD;
          end
          3'd3: begin
            cmd_o.mul_a  = MA_COL1;
            cmd_o.mul_b  = MB_SIN;
            cmd_o.acc_op = ACC_LOAD;
            cmd_o.cap_n1 = 1'b1;
          end
          3'd4: cmd_o.acc_op = ACC_SUB;
          default: begin
            cmd_o.write_row = 1'b1;
            cmd_o.rotate    = 1'b1;
            ph_d  = '0;
            row_d = row_q + 2'd1;
            if (row_q == 2'd2) begin
              row_d   = '0;
              state_d = stat_i.chain_end ? ST_ROWS : ST_IDLE;
            end
          end
        endcase
      end
      // Emit final rows from the head
      ST_ROWS: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_ROW;
          cmd_o.out_row  = row_q;
          cmd_o.out_last = (row_q == 2'd2);
          cmd_o.rotate   = 1'b1;
          row_d = row_q + 2'd1;
          if (row_q == 2'd2) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      ph_q    <= ph_d;
    end
  end

endmodule

[hw/rtl/dh_chain_axis_offset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dh_chain_axis_offset_top
// DH joint chain to joint axes, joint offsets and final rotation rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one joint word: twist
//   angle, link length, link offset, chain start and chain end flags.
//   Output channel (out_valid_o / out_stall_i) gives the joint axis, then
//   the joint offset, and with chain end the three final rotation rows;
//   run_last_o marks the last word of each joint.
//   One shared 18x32 multiplier runs 4 steps per offset row and 6 per
//   rotation row, while the CORDIC runs beside the offset work; output
//   stalls add to the time a joint takes, and with chain end the final
//   rows follow, one per output word.
//   in_stall_o is high while a joint is in progress.
//   The first word is registered after the take, once the output is free.
//   A held output word keeps the sequencer waiting at its next word.
//   Reset sets the rotation to identity and empties the output register.
// ----------------------------------------------------------------------------
module dh_chain_axis_offset_top #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] twist_angle_i,
  input  logic signed [31:0] link_length_i,
  input  logic signed [31:0] link_offset_i,
  input  logic               chain_start_i,
  input  logic               chain_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] comp_x_o,
  output logic signed [31:0] comp_y_o,
  output logic signed [31:0] comp_z_o,
  output logic               run_last_o
);
  import dhc_pkg::*;

  dhc_cmd_t  cmd;
  dhc_stat_t stat;

  dhc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dhc_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .twist_angle_i(twist_angle_i),
    .link_length_i(link_length_i),
    .link_offset_i(link_offset_i),
    .chain_start_i(chain_start_i),
    .chain_end_i  (chain_end_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .result_kind_o(result_kind_o),
    .row_index_o  (row_index_o),
    .comp_x_o     (comp_x_o),
    .comp_y_o     (comp_y_o),
    .comp_z_o     (comp_z_o),
    .run_last_o   (run_last_o)
  );

`ifndef SYNTH
  // A taken joint blocks the next one
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("joint taken but input not stalled");

  // An axis word never closes a joint
  a_axis_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_AXIS) |-> !run_last_o)
    else $error("axis word marked last");

  // Row index is only used by rotation rows
  a_row_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_ROW) |-> (row_index_o == 2'd0))
    else $error("row index set on non-row word");
`endif

endmodule

[dv/dh_chain_axis_offset_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dh_chain_axis_offset_top_tb
// Self-checking bench for the DH chain axis/offset converter. A driver
// offers joint words from a queue, and a monitor takes result words with
// random stalls. Each result is checked against a bit-exact fixed-point
// model of the running rotation that this bench keeps itself.
// ----------------------------------------------------------------------------
module dh_chain_axis_offset_top_tb;
  import dhc_pkg::*;

  localparam int Frac      = 16;
  localparam int Steps     = 16;
  localparam int CycleCap  = 400000;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [31:0] len;
    logic signed [31:0] ofs;
    logic               first;
    logic               last_joint;
  } joint_t;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         row;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } result_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] twist_angle;
  logic signed [31:0] link_length, link_offset;
  logic chain_start, chain_end;
  logic [1:0] result_kind, row_index;
  logic signed [31:0] comp_x, comp_y, comp_z;
  logic run_last;

  joint_t  joint_q[$];
  result_t expected_words[$];
  longint  rot[9];
  int      errors = 0;
  int      cycles = 0;
  int      hold_off = 0;
  bit      long_hold_req = 0;
  bit      stim_done = 0;

  dh_chain_axis_offset_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .twist_angle_i(twist_angle), .link_length_i(link_length),
    .link_offset_i(link_offset), .chain_start_i(chain_start),
    .chain_end_i(chain_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_kind_o(result_kind), .row_index_o(row_index),
    .comp_x_o(comp_x), .comp_y_o(comp_y), .comp_z_o(comp_z),
    .run_last_o(run_last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Floor shift, rounding half up, clamping
  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    return 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic void rot_identity();
    for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? (longint'(1) << Frac) : 0;
  endfunction

  task automatic twist_sincos(input longint ang, output longint c, output longint s);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = 652032874;
    y = 0;
    if (ang > 16384) begin
      ang -= 32768; flip = 1;
    end else if (ang < -16384) begin
      ang += 32768; flip = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_at(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_at(5'(i)));
      end
    end
    c = clip(rnd(x, CordFrac - Frac), -(longint'(1) << Frac), longint'(1) << Frac);
    s = clip(rnd(y, CordFrac - Frac), -(longint'(1) << Frac), longint'(1) << Frac);
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  // Advance the rotation by one joint and queue the words it causes
  task automatic predict_joint(input joint_t j);
    result_t w;
    longint  c, s, m1, m2, a, d, emax, emin;
    longint  o[3];
    emax = (longint'(1) << (Frac + 1)) - 1;
    emin = -(longint'(1) << (Frac + 1));
    a = j.len;
    d = j.ofs;
    if (j.first) rot_identity();
    w = '{KIND_AXIS, 2'd0, sat32(rot[2]), sat32(rot[5]), sat32(rot[8]), 1'b0};
    expected_words.push_back(w);
    for (int r = 0; r < 3; r++) o[r] = rnd(rot[r*3] * a + rot[r*3+2] * d, Frac);
    w = '{KIND_OFFSET, 2'd0, sat32(o[0]), sat32(o[1]), sat32(o[2]), !j.last_joint};
    expected_words.push_back(w);
    twist_sincos(longint'(j.angle), c, s);
    for (int r = 0; r < 3; r++) begin
      m1 = rot[r*3+1];
      m2 = rot[r*3+2];
      rot[r*3+1] = clip(rnd(m1 * c + m2 * s, Frac), emin, emax);
      rot[r*3+2] = clip(rnd(m2 * c - m1 * s, Frac), emin, emax);
    end
    if (j.last_joint) begin
      for (int r = 0; r < 3; r++) begin
        w = '{KIND_ROW, 2'(r), sat32(rot[r*3]), sat32(rot[r*3+1]), sat32(rot[r*3+2]),
              r == 2};
        expected_words.push_back(w);
      end
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Fill the joint queue: directed corners, then random chains
  initial begin
    joint_t j;
    int     n;
    rot_identity();
    joint_q.push_back('{16'sh0000, 32'h00010000, 32'h00020000, 1'b0, 1'b0});
    joint_q.push_back('{16'sh7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1});
    joint_q.push_back('{-16'sd32768, 32'h80000000, 32'h80000000, 1'b1, 1'b1});
    joint_q.push_back('{16'sd16384, 32'hFFFFFFFF, 32'h00000001, 1'b1, 1'b0});
    joint_q.push_back('{16'sd16385, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0});
    joint_q.push_back('{-16'sd16384, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0});
    joint_q.push_back('{-16'sd16385, 32'h00008000, 32'hFFFF8000, 1'b0, 1'b1});
    joint_q.push_back('{16'sh5555, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0});
    joint_q.push_back('{16'shAAAA, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0});
    joint_q.push_back('{16'sd8192, 32'h80000000, 32'h80000000, 1'b0, 1'b1});
    joint_q.push_back('{16'sd1, 32'h0, 32'h0, 1'b1, 1'b1});
    joint_q.push_back('{-16'sd1, 32'h12345678, 32'hEDCBA987, 1'b0, 1'b1});
    n = 0;
    while (n < 150) begin
      int len;
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        j.angle = 16'($urandom);
        if ($urandom_range(0, 7) == 0) j.angle = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        j.len = rand_len();
        j.ofs = rand_len();
        j.first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        j.last_joint = (k == len - 1) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 19) == 0);
        joint_q.push_back(j);
        n++;
      end
    end
    stim_done = 1;
  end

  // Driver: present joint words on the falling edge
  initial begin
    in_valid = 0;
    {twist_angle, link_length, link_offset, chain_start, chain_end} = '0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1;
  end

  int  in_gap = 0;
  bit  in_taken;
  int  sent = 0;
  always @(posedge clk) begin
    in_taken = in_valid && !in_stall && rst_n;
    if (in_taken) begin
      predict_joint('{twist_angle, link_length, link_offset, chain_start, chain_end});
      sent++;
      if (sent == 40) long_hold_req = 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_valid <= 0;
        in_gap = gap_len();
        in_taken = 0;
      end
      if (!in_valid || in_taken) begin
        if (in_gap > 0) in_gap--;
        else if (joint_q.size() > 0) begin
          joint_t j;
          j = joint_q.pop_front();
          {twist_angle, link_length, link_offset, chain_start, chain_end} <= j;
          in_valid <= 1;
        end
      end
    end
  end

  // Receiver stall pattern, including one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (long_hold_req) begin
      long_hold_req = 0;
      hold_off = 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off--;
      out_stall <= (hold_off > 0) || ($urandom_range(0, 1) == 0);
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      hold_off = gap_len();
    end else out_stall <= 1'b0;
  end

  // Monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind_e'(result_kind), row_index, comp_x, comp_y, comp_z, run_last};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Drain, settle, decide
  initial begin
    @(posedge rst_n);
    wait (stim_done && joint_q.size() == 0 && !in_valid && expected_words.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
